// ===== sv/psc_pkg.sv =====
// Shared types and constants for the press cylinder sequencer.
`default_nettype none

package psc_pkg;

    localparam int DUR_BITS   = 10;
    localparam int REG_W      = 60;
    localparam int STATION_W  = 3;
    localparam int ENABLE_W   = 6;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOWN   = 2'd0,
        CFG_DWELL  = 2'd1,
        CFG_UP     = 2'd2,
        CFG_ENABLE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_HOME   = 2'd0,
        PH_PRESS  = 2'd1,
        PH_DWELL  = 2'd2,
        PH_RETURN = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        DRV_STOP = 2'd0,
        DRV_DOWN = 2'd1,
        DRV_UP   = 2'd2
    } t_drive;

    typedef struct packed {
        t_phase              phase;
        t_drive              drive;
        logic                running;
        logic [DUR_BITS-1:0] timeout;
    } t_ctl;

    function automatic logic [DUR_BITS-1:0] field_of(input logic [REG_W-1:0] reg_v,
                                                      input logic [STATION_W-1:0] idx);
        field_of = reg_v[idx*DUR_BITS +: DUR_BITS];
    endfunction

endpackage

`default_nettype wire

// ===== sv/press_cylinder_sequencer_core.sv =====
// Press cylinder sequencer: per-station state in memory, read-modify-write pipeline.
//
// Six (STATIONS) pneumatic press stations share one pipeline. Each request on the
// s_axis channel is an evaluation pass (tuser 0) or a timer tick (tuser 1) for one
// station; s_axis_tdata holds station[2:0], forward_pedal_n[3], reverse_pedal_n[4].
// Every request yields exactly one result on m_axis in request order.
// The cfg channel writes index 0 down, 1 dwell, 2 up durations (six 10-bit fields,
// station 0 lowest) and index 3 the station enable mask; it is always ready and the
// user must write it only while the pipeline is empty; the block does not enforce this.
// The station entry is read from a synchronous memory into the update stage at
// acceptance, then updated, written back and registered at the output.
// Throughput is one request per cycle while m_axis is not stalled; back-to-back requests
// to the same station take the written-back entry through a forwarding register.
// Reset clears the per-entry valid bits, so every station reads as home, stopped,
// count zero, timer stopped; all durations and enables clear to zero.
// When m_axis stalls the result holds in the output register and one more request
// waits in the update stage; s_axis_tready drops only when both are full.
`default_nettype none

module press_cylinder_sequencer_core #(
    parameter int STATIONS   = 6,
    parameter int COUNT_BITS = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // cfg write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [psc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [psc_pkg::REG_W-1:0]      i_cfg_data,
    // request stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // station, forward_pedal_n, reverse_pedal_n
    input  wire logic                           s_axis_tuser,  // op
    // result stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [((3+2+2+COUNT_BITS+1+7)/8)*8-1:0] m_axis_tdata // out_station, drive, phase, tick_count, timer_on
);
    import psc_pkg::*;

    localparam int AW     = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam int CW     = (COUNT_BITS > DUR_BITS) ? COUNT_BITS : DUR_BITS;
    localparam int OUT_W  = STATION_W + 2 + 2 + COUNT_BITS + 1;
    localparam int TD_W   = ((OUT_W + 7) / 8) * 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [STATION_W-1:0]  NUM_ST    = STATION_W'(STATIONS);

    // configuration registers
    logic [REG_W-1:0]    r_down, r_dwell, r_up;
    logic [ENABLE_W-1:0] r_enable;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down   <= '0;
            r_dwell  <= '0;
            r_up     <= '0;
            r_enable <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DOWN:   r_down   <= i_cfg_data;
                CFG_DWELL:  r_dwell  <= i_cfg_data;
                CFG_UP:     r_up     <= i_cfg_data;
                CFG_ENABLE: r_enable <= i_cfg_data[ENABLE_W-1:0];
                default:    ;
            endcase
        end
    end

    // station memories
    t_ctl                  mem_ctl [STATIONS];
    logic [COUNT_BITS-1:0] mem_cnt [STATIONS];
    logic [STATIONS-1:0]   r_vld;

    // request decode
    logic                 in_acc;
    logic [STATION_W-1:0] in_station;
    logic                 in_inrange;
    logic [AW-1:0]        in_addr;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign in_station = s_axis_tdata[STATION_W-1:0];
    assign in_inrange = (in_station < NUM_ST);
    assign in_addr    = in_station[AW-1:0];

    // update stage registers
    logic                  r_s1_valid;
    logic                  r_s1_op;
    logic [STATION_W-1:0]  r_s1_station;
    logic                  r_s1_inrange;
    logic                  r_s1_fwd;
    logic                  r_s1_rev;
    t_ctl                  r_rd_ctl;
    logic [COUNT_BITS-1:0] r_rd_cnt;
    logic                  r_rd_vld;
    logic                  r_fwd_hit;
    t_ctl                  r_fwd_ctl;
    logic [COUNT_BITS-1:0] r_fwd_cnt;

    // output register
    logic                  r_out_valid;
    logic [TD_W-1:0]       r_out_data;

    logic s1_adv;
    logic s1_wr;
    logic [AW-1:0] s1_addr;

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign s1_wr         = s1_adv && r_s1_inrange;
    assign s1_addr       = r_s1_station[AW-1:0];

    // read-modify-write
    t_ctl                  cur_ctl, n_ctl;
    logic [COUNT_BITS-1:0] cur_cnt, n_cnt;
    logic [DUR_BITS-1:0]   down_d, dwell_d, up_d;
    logic                  en;
    logic                  cnt_done;
    logic                  cnt_done_new;
    logic                  cnt_full;
    logic [OUT_W-1:0]      n_out;

    always_comb begin
        if (r_fwd_hit) begin
            cur_ctl = r_fwd_ctl;
            cur_cnt = r_fwd_cnt;
        end else if (r_rd_vld) begin
            cur_ctl = r_rd_ctl;
            cur_cnt = r_rd_cnt;
        end else begin
            cur_ctl = '0;
            cur_cnt = '0;
        end

        down_d  = field_of(r_down,  r_s1_station);
        dwell_d = field_of(r_dwell, r_s1_station);
        up_d    = field_of(r_up,    r_s1_station);
        en      = r_enable[r_s1_station];

        cnt_done     = (CW'(cur_cnt) >= CW'(cur_ctl.timeout));
        cnt_done_new = (CW'(cur_cnt) >= CW'(down_d));
        cnt_full     = (cur_cnt == COUNT_MAX);

        n_ctl = cur_ctl;
        n_cnt = cur_cnt;

        if (!r_s1_op) begin
            if (en) begin
                unique case (cur_ctl.phase)
                    PH_HOME: begin
                        if (!r_s1_fwd) begin
                            n_ctl.drive   = DRV_DOWN;
                            n_ctl.timeout = down_d;
                            n_ctl.running = 1'b1;
                            if (cnt_done_new) begin
                                n_ctl.phase = PH_PRESS;
                            end
                        end else if (!r_s1_rev) begin
                            if (cur_cnt != '0) begin
                                n_ctl.timeout = down_d;
                                n_ctl.running = 1'b1;
                                n_ctl.drive   = DRV_UP;
                            end else begin
                                n_ctl.drive = DRV_STOP;
                            end
                        end else begin
                            // stop at home keeps the count
                            n_ctl.running = 1'b0;
                            n_ctl.drive   = DRV_STOP;
                        end
                    end
                    PH_PRESS: begin
                        if (cnt_done) begin
                            n_cnt         = '0;
                            n_ctl.drive   = DRV_STOP;
                            n_ctl.phase   = PH_DWELL;
                            n_ctl.timeout = dwell_d;
                            n_ctl.running = 1'b1;
                        end
                    end
                    PH_DWELL: begin
                        if (cnt_done) begin
                            n_cnt         = '0;
                            n_ctl.timeout = up_d;
                            n_ctl.running = 1'b1;
                            n_ctl.phase   = PH_RETURN;
                            n_ctl.drive   = DRV_UP;
                        end
                    end
                    PH_RETURN: begin
                        if (cnt_done) begin
                            n_cnt         = '0;
                            n_ctl.running = 1'b0;
                            n_ctl.drive   = DRV_STOP;
                            n_ctl.phase   = PH_HOME;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (cur_ctl.running) begin
            if (cur_ctl.phase == PH_HOME) begin
                priority if (cur_ctl.drive == DRV_DOWN) begin
                    if (!cnt_full) begin
                        n_cnt = cur_cnt + 1'b1;
                    end
                end else if (cur_ctl.drive == DRV_UP) begin
                    if (cur_cnt != '0) begin
                        n_cnt = cur_cnt - 1'b1;
                    end
                end else begin
                end
            end else if (!cnt_full) begin
                n_cnt = cur_cnt + 1'b1;
            end
        end

        if (r_s1_inrange) begin
            n_out = {n_ctl.running, n_cnt, n_ctl.phase, n_ctl.drive, r_s1_station};
        end else begin
            n_out = {{(OUT_W-STATION_W){1'b0}}, r_s1_station};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            mem_ctl[s1_addr] <= n_ctl;
            mem_cnt[s1_addr] <= n_cnt;
        end
        if (in_acc) begin
            r_rd_ctl <= mem_ctl[in_addr];
            r_rd_cnt <= mem_cnt[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s1_wr) begin
            r_vld[s1_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                // entry written at the same edge it is read: take the written copy
                r_fwd_hit  <= s1_wr && (s1_addr == in_addr);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op      <= s_axis_tuser;
            r_s1_station <= in_station;
            r_s1_inrange <= in_inrange;
            r_s1_fwd     <= s_axis_tdata[STATION_W];
            r_s1_rev     <= s_axis_tdata[STATION_W+1];
            r_rd_vld     <= r_vld[in_addr];
        end
        if (s1_wr) begin
            r_fwd_ctl <= n_ctl;
            r_fwd_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= TD_W'(n_out);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
